### rtl/fvws_pkg.sv
// shared constants, command and waveform codes and voice control for the four voice synth
package fvws_pkg;

  localparam int VOICES_DEF     = 4;
  localparam int LEVEL_BITS_DEF = 10;
  localparam int VOL_BITS_DEF   = 8;
  localparam int VOL_RESET_DEF  = 63;

  localparam int CMD_BITS   = 2;
  localparam int VOICE_BITS = 2;
  localparam int VALUE_BITS = 31;
  localparam int NOISE_BITS = 4;
  localparam int PHASE_BITS = 31;

  localparam logic [PHASE_BITS-1:0] HALF_PHASE = 31'h4000_0000;
  localparam logic [PHASE_BITS-1:0] FULL_PHASE = 31'h7fff_ffff;

  localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_VOL  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_WAVE = 2'd3;

  typedef enum logic [1:0] {
    WAVE_SQUARE = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_NOISE  = 2'd3
  } wave_t;

  typedef struct packed {
    logic tick;
    logic wr_step;
    logic wr_vol;
    logic wr_wave;
  } voice_ctrl_t;

endpackage

### rtl/fvws_in_if.sv
// input channel: ticks and voice register writes
interface fvws_in_if;
  import fvws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   cmd;
  logic [VOICE_BITS-1:0] voice;
  logic [VALUE_BITS-1:0] value;
  logic [NOISE_BITS-1:0] noise_bits;

  modport source (output valid, cmd, voice, value, noise_bits, input ready);
  modport sink (input valid, cmd, voice, value, noise_bits, output ready);
endinterface

### rtl/fvws_out_if.sv
// output channel: one pwm level per tick
interface fvws_out_if #(
  parameter int LEVEL_BITS = fvws_pkg::LEVEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;

  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

### rtl/fvws_voice.sv
// one voice: phase accumulator, voice registers and waveform level
module fvws_voice #(
  parameter int LEVEL_BITS = fvws_pkg::LEVEL_BITS_DEF,
  parameter int VOL_BITS   = fvws_pkg::VOL_BITS_DEF,
  parameter int VOL_RESET  = fvws_pkg::VOL_RESET_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fvws_pkg::voice_ctrl_t             ctrl,
  input  logic [fvws_pkg::VALUE_BITS-1:0]   value,
  input  logic [VOL_BITS-1:0]               vol_in,
  input  logic                              noise,
  output logic [VOL_BITS-1:0]               level
);
  import fvws_pkg::*;

  localparam int PROD_BITS = LEVEL_BITS + VOL_BITS + 1;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_step;
  logic [VOL_BITS-1:0]   vol;
  wave_t                 wave;

  logic [PHASE_BITS:0]   phase_sum;
  logic [PHASE_BITS-1:0] phase_next;
  logic [LEVEL_BITS:0]   mult_a;
  logic [PROD_BITS-1:0]  prod;
  logic [VOL_BITS:0]     scaled;
  logic [VOL_BITS-1:0]   tri_level;

  // wrap by subtracting the full scale once past it
  assign phase_sum  = {1'b0, phase} + {1'b0, phase_step};
  assign phase_next = (phase_sum > {1'b0, FULL_PHASE})
                    ? PHASE_BITS'(phase_sum - {1'b0, FULL_PHASE})
                    : phase_sum[PHASE_BITS-1:0];

  // saw and triangle share one multiplier; triangle takes one more phase bit
  assign mult_a = (wave == WAVE_TRI) ? phase_next[PHASE_BITS-1 -: LEVEL_BITS+1]
                                     : {1'b0, phase_next[PHASE_BITS-1 -: LEVEL_BITS]};
  assign prod   = PROD_BITS'(mult_a) * PROD_BITS'(vol);
  assign scaled = prod[LEVEL_BITS +: VOL_BITS+1];

  // falling half of the triangle folds back from twice the volume
  assign tri_level = (scaled < {1'b0, vol}) ? scaled[VOL_BITS-1:0]
                                            : VOL_BITS'({vol, 1'b0} - scaled);

  always_comb begin
    unique case (wave)
      WAVE_SQUARE: level = (phase_next > HALF_PHASE) ? vol : '0;
      WAVE_SAW:    level = scaled[VOL_BITS-1:0];
      WAVE_TRI:    level = tri_level;
      WAVE_NOISE:  level = noise ? vol : '0;
      default:     level = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= '0;
      vol        <= VOL_BITS'(VOL_RESET);
      wave       <= WAVE_SQUARE;
    end else begin
      if (ctrl.tick) begin
        phase <= phase_next;
      end
      if (ctrl.wr_step) begin
        phase_step <= value;
      end
      if (ctrl.wr_vol) begin
        vol <= vol_in;
      end
      if (ctrl.wr_wave) begin
        wave <= (value > VALUE_BITS'(WAVE_NOISE)) ? WAVE_NOISE : wave_t'(value[1:0]);
      end
    end
  end
endmodule

### rtl/four_voice_waveform_synth.sv
// four voice waveform synth top level: input register, voice bank, level sum and output register
// a tick goes through the input, level and output registers before its level reaches samples
// one item per cycle while no tick stalls, ticks and writes mixed; writes never wait on output
// the ready path runs combinationally from samples.ready back through three stage registers
// reset (synchronous, rst high): pipeline emptied, phases and steps zero, volumes
// (span-1)/4, all voices square
module four_voice_waveform_synth #(
  parameter int VOICES     = fvws_pkg::VOICES_DEF,
  parameter int LEVEL_BITS = fvws_pkg::LEVEL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fvws_in_if.sink           items,
  fvws_out_if.source        samples
);
  import fvws_pkg::*;

  // volume span per voice, so that the sum of all voices fits the level width
  localparam int VOL_SPAN   = (1 << LEVEL_BITS) / VOICES;
  localparam int VOL_BITS   = $clog2(VOL_SPAN);
  localparam int VOL_RESET  = (VOL_SPAN - 1) / 4;
  localparam int LEVEL_MAX  = VOICES * (VOL_SPAN - 1);

  // value mod span: quotient estimate by reciprocal, at most one low, then one correction
  localparam int           RSHIFT     = VALUE_BITS + VOL_BITS;
  localparam int           RECIP_BITS = VALUE_BITS + 1;
  localparam int           RPROD_BITS = VALUE_BITS + RECIP_BITS;
  localparam int           Q_BITS     = VALUE_BITS - VOL_BITS + 1;
  localparam int           WIDE       = VALUE_BITS + 1;
  localparam logic [63:0]  RECIP      = (64'd1 << RSHIFT) / VOL_SPAN;

  // ---------------------------------------------------------------- ready chain
  logic c_valid;
  logic b_valid;
  logic a_valid;
  logic c_free;
  logic b_free;
  logic a_done;
  logic a_tick;
  logic accept;

  logic [CMD_BITS-1:0]   a_cmd;
  logic [VOICE_BITS-1:0] a_voice;
  logic [VALUE_BITS-1:0] a_value;
  logic [NOISE_BITS-1:0] a_noise;
  logic [Q_BITS-1:0]     a_quot;

  assign c_free      = !c_valid || samples.ready;
  assign b_free      = !b_valid || c_free;
  // a write retires on its own; a tick needs room in the level stage
  assign a_done      = a_valid && ((a_cmd != CMD_TICK) || b_free);
  assign a_tick      = a_done && (a_cmd == CMD_TICK);
  assign items.ready = !a_valid || a_done;
  assign accept      = items.valid && items.ready;

  // ---------------------------------------------------------------- input stage
  // reciprocal multiply on the way into the input register
  logic [RPROD_BITS-1:0] recip_prod;
  assign recip_prod = RPROD_BITS'(items.value) * RPROD_BITS'(RECIP[RECIP_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_done) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd   <= items.cmd;
      a_voice <= items.voice;
      a_value <= items.value;
      a_noise <= items.noise_bits;
      a_quot  <= recip_prod[RSHIFT +: Q_BITS];
    end
  end

  // remainder lands in [0, 2*span); one compare and subtract finishes it
  logic [WIDE-1:0]     quot_span;
  logic [WIDE-1:0]     rem_full;
  logic [VOL_BITS:0]   rem_lo;
  logic [VOL_BITS-1:0] vol_rem;

  assign quot_span = WIDE'(a_quot) * WIDE'(VOL_SPAN);
  assign rem_full  = {1'b0, a_value} - quot_span;
  assign rem_lo    = rem_full[VOL_BITS:0];
  assign vol_rem   = (rem_lo >= (VOL_BITS+1)'(VOL_SPAN))
                   ? VOL_BITS'(rem_lo - (VOL_BITS+1)'(VOL_SPAN))
                   : rem_lo[VOL_BITS-1:0];

  // ---------------------------------------------------------------- voice bank
  logic [VOL_BITS-1:0] voice_level [VOICES];
  logic [VOL_BITS-1:0] b_level     [VOICES];

  for (genvar v = 0; v < VOICES; v++) begin : g_voice
    voice_ctrl_t ctrl;
    logic        hit;
    logic        nbit;

    // a write to a voice number past the bank matches nothing and is dropped
    assign hit          = (int'(a_voice) == v);
    assign ctrl.tick    = a_tick;
    assign ctrl.wr_step = a_done && hit && (a_cmd == CMD_STEP);
    assign ctrl.wr_vol  = a_done && hit && (a_cmd == CMD_VOL);
    assign ctrl.wr_wave = a_done && hit && (a_cmd == CMD_WAVE);

    // voices past the noise field see a zero noise bit
    if (v < NOISE_BITS) begin : g_noise
      assign nbit = a_noise[v];
    end else begin : g_no_noise
      assign nbit = 1'b0;
    end

    fvws_voice #(
      .LEVEL_BITS (LEVEL_BITS),
      .VOL_BITS   (VOL_BITS),
      .VOL_RESET  (VOL_RESET)
    ) u_voice (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .value  (a_value),
      .vol_in (vol_rem),
      .noise  (nbit),
      .level  (voice_level[v])
    );
  end

  // ---------------------------------------------------------------- level stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_tick) begin
      b_valid <= 1'b1;
    end else if (c_free) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_tick) begin
      b_level <= voice_level;
    end
  end

  // ---------------------------------------------------------------- sum and output
  // each voice stays below the span, so the sum never overflows the level width
  logic [LEVEL_BITS-1:0] level_sum;
  logic [LEVEL_BITS-1:0] c_level;

  always_comb begin
    level_sum = '0;
    for (int v = 0; v < VOICES; v++) begin
      level_sum = level_sum + LEVEL_BITS'(b_level[v]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (b_valid && c_free) begin
      c_valid <= 1'b1;
    end else if (samples.ready) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_free) begin
      c_level <= level_sum;
    end
  end

  assign samples.valid = c_valid;
  assign samples.level = c_level;

  // ---------------------------------------------------------------- assertions
  a_write_no_stall: assert property (@(posedge clk) disable iff (rst)
    (a_valid && (a_cmd != CMD_TICK)) |-> items.ready)
    else $error("register write held in the input stage");

  a_level_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(b_valid) |-> $past(a_valid && (a_cmd == CMD_TICK)))
    else $error("level stage filled by something other than a tick");

  a_vol_in_span: assert property (@(posedge clk) disable iff (rst)
    (a_valid && (a_cmd == CMD_VOL)) |-> (vol_rem < VOL_BITS'(VOL_SPAN - 1) ||
                                         vol_rem == VOL_BITS'(VOL_SPAN - 1)))
    else $error("volume remainder out of span");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> (c_level < LEVEL_BITS'(LEVEL_MAX) || c_level == LEVEL_BITS'(LEVEL_MAX)))
    else $error("summed level above the largest reachable value");

endmodule

### tb/sv/tb.sv
// testbench for the four voice waveform synth: directed and random items checked against a level predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fvws_pkg::*;

  localparam int VOL_SPAN     = (1 << LEVEL_BITS_DEF) / VOICES_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT        = 200000;

  // predicts the pwm level of every tick and keeps the levels still owed by the block
  class synth_model;
    logic [PHASE_BITS-1:0]   phase[VOICES_DEF];
    logic [PHASE_BITS-1:0]   step[VOICES_DEF];
    logic [VOL_BITS_DEF-1:0] vol[VOICES_DEF];
    wave_t                   wave[VOICES_DEF];
    logic [LEVEL_BITS_DEF-1:0] levels_due[$];
    int errors;

    function new();
      for (int v = 0; v < VOICES_DEF; v++) begin
        phase[v] = '0;
        step[v]  = '0;
        vol[v]   = VOL_BITS_DEF'(VOL_RESET_DEF);
        wave[v]  = WAVE_SQUARE;
      end
      errors = 0;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function int unsigned voice_out(int v, logic noise_bit);
      int unsigned p, a, t;
      p = 32'(phase[v]);
      a = 32'(vol[v]);
      case (wave[v])
        WAVE_SQUARE: return (p > HALF_PHASE) ? a : 0;
        WAVE_SAW:    return ((p >> (31 - LEVEL_BITS_DEF)) * a) >> LEVEL_BITS_DEF;
        WAVE_TRI: begin
          t = ((p >> (30 - LEVEL_BITS_DEF)) * a) >> LEVEL_BITS_DEF;
          return (t < a) ? t : (2 * a - t);
        end
        default:     return noise_bit ? a : 0;
      endcase
    endfunction

    function void note_item(logic [CMD_BITS-1:0] cmd, logic [VOICE_BITS-1:0] voice,
                            logic [VALUE_BITS-1:0] value, logic [NOISE_BITS-1:0] noise);
      logic [PHASE_BITS:0] acc;
      int unsigned sum;
      case (cmd)
        CMD_STEP: step[voice] = value;
        CMD_VOL:  vol[voice] = VOL_BITS_DEF'(value % VOL_SPAN);
        CMD_WAVE: wave[voice] = (value > VALUE_BITS'(WAVE_NOISE)) ? WAVE_NOISE
                                                                  : wave_t'(value[1:0]);
        default: begin
          sum = 0;
          for (int v = 0; v < VOICES_DEF; v++) begin
            acc = {1'b0, phase[v]} + {1'b0, step[v]};
            if (acc > {1'b0, FULL_PHASE}) acc = acc - {1'b0, FULL_PHASE};
            phase[v] = acc[PHASE_BITS-1:0];
          end
          for (int v = 0; v < VOICES_DEF; v++) sum += voice_out(v, noise[v]);
          levels_due.push_back(LEVEL_BITS_DEF'(sum));
        end
      endcase
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch: %s, got %0d, want %0d", what, got, want);
    endtask

    task check_level(logic [LEVEL_BITS_DEF-1:0] got);
      logic [LEVEL_BITS_DEF-1:0] want;
      if (levels_due.size() == 0) begin
        report_mismatch("level with no tick waiting", got, -1);
      end else begin
        want = levels_due.pop_front();
        if (got !== want) report_mismatch("level", got, want);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  fvws_in_if                                   in_ch();
  fvws_out_if #(.LEVEL_BITS(LEVEL_BITS_DEF))   out_ch();

  four_voice_waveform_synth #(
    .VOICES     (VOICES_DEF),
    .LEVEL_BITS (LEVEL_BITS_DEF)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .samples (out_ch)
  );

  synth_model sb = new();

  // calm turns off idling on both sides, hold_req asks the receiver for a long stall
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int cycles   = 0;

  always #5 clk = ~clk;

  // run guard: a stuck handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // one process watches both channels so noting and checking see the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.cmd, in_ch.voice, in_ch.value, in_ch.noise_bits);
      if (out_ch.valid && out_ch.ready)
        sb.check_level(out_ch.level);
    end
  end

  // receiver: random backpressure, none while calm, and one long stall on request
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 33);
        @(posedge clk);
      end
    end
  end

  // offer one item and hold it until the block takes it
  task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [VOICE_BITS-1:0] voice,
                           logic [VALUE_BITS-1:0] value, logic [NOISE_BITS-1:0] noise);
    while (!calm && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.voice      <= voice;
    in_ch.value      <= value;
    in_ch.noise_bits <= noise;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // mostly ticks, with writes mixed in; values reach every bit and the wraps
  task automatic send_random_item();
    int unsigned pick, shape;
    logic [VALUE_BITS-1:0] value;
    pick  = $urandom_range(99);
    shape = $urandom_range(3);
    value = VALUE_BITS'($urandom);
    if (pick < 60) begin
      send_item(CMD_TICK, VOICE_BITS'($urandom), value, NOISE_BITS'($urandom));
    end else if (pick < 75) begin
      // steps: full range, slow sweeps, and steps near the wrap point
      if (shape == 0) value = VALUE_BITS'($urandom_range(32'hfffff));
      else if (shape == 1) value = FULL_PHASE - VALUE_BITS'($urandom_range(32'hffff));
      send_item(CMD_STEP, VOICE_BITS'($urandom), value, NOISE_BITS'($urandom));
    end else if (pick < 87) begin
      if (shape < 2) value = VALUE_BITS'($urandom_range(VOL_SPAN - 1));
      send_item(CMD_VOL, VOICE_BITS'($urandom), value, NOISE_BITS'($urandom));
    end else begin
      // waveform codes, now and then an oversized one that lands on noise
      if (shape != 0) value = VALUE_BITS'($urandom_range(WAVE_NOISE));
      send_item(CMD_WAVE, VOICE_BITS'($urandom), value, NOISE_BITS'($urandom));
    end
  endtask

  // wait on the clock first, so the last accepted item is already noted
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin
    // every input is driven to a known value before the first edge
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.voice      <= '0;
    in_ch.value      <= '0;
    in_ch.noise_bits <= '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: zero phases, all square, so the first tick gives zero
    send_item(CMD_TICK, 2'd0, '0, 4'hf);
    // steps at the extremes: largest, exactly half, smallest, just past half
    send_item(CMD_STEP, 2'd0, FULL_PHASE, 4'h0);
    send_item(CMD_STEP, 2'd1, HALF_PHASE, 4'h0);
    send_item(CMD_STEP, 2'd2, 31'd1, 4'h0);
    send_item(CMD_STEP, 2'd3, HALF_PHASE + 31'd1, 4'h0);
    send_item(CMD_TICK, 2'd3, FULL_PHASE, 4'h0);
    send_item(CMD_TICK, 2'd1, '0, 4'hf);
    // volumes: zero, top, the span itself (wraps to zero), all ones
    send_item(CMD_VOL, 2'd0, '0, 4'h0);
    send_item(CMD_VOL, 2'd1, 31'd255, 4'h0);
    send_item(CMD_VOL, 2'd2, 31'(VOL_SPAN), 4'h0);
    send_item(CMD_VOL, 2'd3, FULL_PHASE, 4'h0);
    send_item(CMD_TICK, 2'd0, '0, 4'h5);
    // every waveform, and oversized codes that store noise
    send_item(CMD_WAVE, 2'd0, 31'(WAVE_SAW), 4'h0);
    send_item(CMD_WAVE, 2'd1, 31'(WAVE_TRI), 4'h0);
    send_item(CMD_WAVE, 2'd2, 31'(WAVE_NOISE), 4'h0);
    send_item(CMD_WAVE, 2'd3, FULL_PHASE, 4'h0);
    send_item(CMD_TICK, 2'd2, '0, 4'h5);
    send_item(CMD_TICK, 2'd0, '0, 4'ha);
    send_item(CMD_VOL, 2'd0, 31'd255, 4'h0);
    send_item(CMD_WAVE, 2'd2, 31'd4, 4'h0);
    send_item(CMD_TICK, 2'd1, '0, 4'hf);
    send_item(CMD_WAVE, 2'd1, 31'(WAVE_SQUARE), 4'h0);
    send_item(CMD_TICK, 2'd0, '0, 4'h0);

    // random items with idling on both sides
    repeat (RANDOM_ITEMS * 3 / 10) send_random_item();

    // back to back stretch, no idling anywhere
    calm = 1'b1;
    repeat (RANDOM_ITEMS / 5) send_random_item();
    calm = 1'b0;

    // long receiver stall while items keep coming, so the block fills and stalls its input
    hold_req = 1'b1;
    repeat (RANDOM_ITEMS / 5) send_random_item();

    // sender pause until every level owed has come out
    in_ch.valid <= 1'b0;
    wait_drained();

    repeat (RANDOM_ITEMS * 3 / 10) send_random_item();

    in_ch.valid <= 1'b0;
    wait_drained();
    // keep clocking past the drain to catch stray levels
    repeat (6) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
